// ===== rtl/core/ims_pkg.sv =====
package ims_pkg;

    localparam int DEF_MAX_SIDE  = 64;
    localparam int DEF_PROB_BITS = 12;

    localparam int ROW_W      = 6;
    localparam int RAND_W     = 12;
    localparam int ENT_W      = 12;
    localparam int TAB_W      = 60;
    localparam int SIDE_REG_W = 7;
    localparam int DIDX_W     = 3;
    localparam int MAG_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 60;

    localparam logic [SIDE_REG_W-1:0] SIDE_RST = SIDE_REG_W'(64);
    localparam logic [TAB_W-1:0]      TAB_RST  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS   = 2'd0,
        CFG_COLS   = 2'd1,
        CFG_TAB_DN = 2'd2,
        CFG_TAB_UP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              accepted;
        logic              spin_out;
        logic [DIDX_W-1:0] delta_index;
        logic              up_inc;
        logic              up_dec;
    } t_eval_res;

endpackage

// ===== rtl/core/ims_ram.sv =====
module ims_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    output logic [WIDTH-1:0]         o_rdata0,
    input  logic                     i_re1,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re0) begin
            o_rdata0 <= r_mem[i_raddr0];
        end
        if (i_re1) begin
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// ===== rtl/core/ims_site_eval.sv =====
module ims_site_eval #(
    parameter int MAX_SIDE  = ims_pkg::DEF_MAX_SIDE,
    parameter int PROB_BITS = ims_pkg::DEF_PROB_BITS
) (
    input  logic [MAX_SIDE-1:0]         i_row_c,
    input  logic [MAX_SIDE-1:0]         i_row_p,
    input  logic [MAX_SIDE-1:0]         i_row_n,
    input  logic [$clog2(MAX_SIDE)-1:0] i_col,
    input  logic [$clog2(MAX_SIDE)-1:0] i_col_p,
    input  logic [$clog2(MAX_SIDE)-1:0] i_col_n,
    input  logic                        i_op,
    input  logic                        i_spin_in,
    input  logic [ims_pkg::RAND_W-1:0]  i_rand_u,
    input  logic [ims_pkg::TAB_W-1:0]   i_tab_dn,
    input  logic [ims_pkg::TAB_W-1:0]   i_tab_up,
    output ims_pkg::t_eval_res          o_res,
    output logic [MAX_SIDE-1:0]         o_row_new
);

    localparam int G = ims_pkg::ENT_W - PROB_BITS;

    logic                             s;
    logic [ims_pkg::DIDX_W-1:0]       cnt;
    logic [ims_pkg::TAB_W-1:0]        tab;
    logic [ims_pkg::ENT_W-1:0]        ent;
    logic [PROB_BITS-1:0]             p;
    logic [PROB_BITS-1:0]             rr;
    logic                             flip;
    logic                             s_new;

    always_comb begin
        s   = i_row_c[i_col];
        cnt = ims_pkg::DIDX_W'(i_row_p[i_col] == s) + ims_pkg::DIDX_W'(i_row_n[i_col] == s)
            + ims_pkg::DIDX_W'(i_row_c[i_col_p] == s) + ims_pkg::DIDX_W'(i_row_c[i_col_n] == s);
        tab = s ? i_tab_up : i_tab_dn;
        unique case (cnt)
            3'd0:    ent = tab[0*ims_pkg::ENT_W +: ims_pkg::ENT_W];
            3'd1:    ent = tab[1*ims_pkg::ENT_W +: ims_pkg::ENT_W];
            3'd2:    ent = tab[2*ims_pkg::ENT_W +: ims_pkg::ENT_W];
            3'd3:    ent = tab[3*ims_pkg::ENT_W +: ims_pkg::ENT_W];
            3'd4:    ent = tab[4*ims_pkg::ENT_W +: ims_pkg::ENT_W];
            default: ent = '0;
        endcase
        p    = ent[ims_pkg::ENT_W-1:G];
        rr   = i_rand_u[ims_pkg::RAND_W-1:G];
        flip = !i_op && ((p == '1) || (rr < p));

        s_new = i_op ? i_spin_in : (s ^ flip);

        o_row_new         = i_row_c;
        o_row_new[i_col]  = s_new;

        o_res.accepted    = flip;
        o_res.spin_out    = s_new;
        o_res.delta_index = i_op ? '0 : cnt;
        o_res.up_inc      = !s && s_new;
        o_res.up_dec      = s && !s_new;
    end

endmodule

// ===== rtl/core/ising_metropolis_spin_update.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------------
// input    | i_valid / o_ready          | i_op i_row i_col i_spin_in i_rand_u
// result   | o_valid / i_ready          | o_accepted o_spin_out o_delta_index
//          |                            | o_magnetization o_site_error
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// each item passes a row read of the site and the row above on the two read ports,
// a read of the row below, then evaluation and, for an in-range site, row write-back.
// after reset a clearing pass writes MAX_SIDE rows with o_ready low;
// config writes are taken at any time.
// a result waiting in the output register stalls the next item only in its evaluation step.
module ising_metropolis_spin_update #(
    parameter int MAX_SIDE  = ims_pkg::DEF_MAX_SIDE,
    parameter int PROB_BITS = ims_pkg::DEF_PROB_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [ims_pkg::ROW_W-1:0]         i_row,
    input  logic [ims_pkg::ROW_W-1:0]         i_col,
    input  logic                              i_spin_in,
    input  logic [ims_pkg::RAND_W-1:0]        i_rand_u,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_accepted,
    output logic                              o_spin_out,
    output logic [ims_pkg::DIDX_W-1:0]        o_delta_index,
    output logic signed [ims_pkg::MAG_W-1:0]  o_magnetization,
    output logic                              o_site_error,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ims_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ims_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CW     = (SIDE_W > ims_pkg::SIDE_REG_W) ? SIDE_W : ims_pkg::SIDE_REG_W;
    localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int MW0    = (2 * CW > CNT_W + 1) ? 2 * CW : CNT_W + 1;
    localparam int MW     = (MW0 > ims_pkg::MAG_W) ? MW0 : ims_pkg::MAG_W;

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_EV} t_state;

    t_state                          r_state;
    logic [IDX_W-1:0]                r_clr;
    logic [ims_pkg::SIDE_REG_W-1:0]  r_rows;
    logic [ims_pkg::SIDE_REG_W-1:0]  r_cols;
    logic [ims_pkg::TAB_W-1:0]       r_tab_dn;
    logic [ims_pkg::TAB_W-1:0]       r_tab_up;
    logic [CNT_W-1:0]                r_up;
    logic [CNT_W-1:0]                n_up;
    logic [IDX_W-1:0]                r_r;
    logic [IDX_W-1:0]                r_rn;
    logic [IDX_W-1:0]                r_c;
    logic [IDX_W-1:0]                r_cp;
    logic [IDX_W-1:0]                r_cn;
    logic                            r_op;
    logic                            r_spin;
    logic [ims_pkg::RAND_W-1:0]      r_rand;
    logic                            r_err;
    logic [MAX_SIDE-1:0]             r_row_c;
    logic [MAX_SIDE-1:0]             r_row_p;
    logic                            r_out_valid;

    logic [CW-1:0]                   rows_eff;
    logic [CW-1:0]                   cols_eff;
    logic [CW-1:0]                   row_w;
    logic [CW-1:0]                   col_w;
    logic [CW-1:0]                   rp_w;
    logic [CW-1:0]                   rn_w;
    logic [CW-1:0]                   cp_w;
    logic [CW-1:0]                   cn_w;
    logic                            site_err;
    logic                            in_acc;
    logic                            done;
    logic [2*CW-1:0]                 area;
    logic [MW-1:0]                   mag_full;

    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic [MAX_SIDE-1:0]             mem_wdata;
    logic                            mem_re0;
    logic [IDX_W-1:0]                mem_raddr0;
    logic [MAX_SIDE-1:0]             mem_rdata0;
    logic                            mem_re1;
    logic [MAX_SIDE-1:0]             mem_rdata1;

    ims_pkg::t_eval_res              ev_res;
    logic [MAX_SIDE-1:0]             ev_row_new;

    function automatic logic [CW-1:0] clamp_side(input logic [ims_pkg::SIDE_REG_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w < CW'(2)) begin
            return CW'(2);
        end else if (w > CW'(MAX_SIDE)) begin
            return CW'(MAX_SIDE);
        end
        return w;
    endfunction

    always_comb begin
        rows_eff = clamp_side(r_rows);
        cols_eff = clamp_side(r_cols);
        row_w    = CW'(i_row);
        col_w    = CW'(i_col);
        rp_w     = (row_w == '0) ? rows_eff - CW'(1) : row_w - CW'(1);
        rn_w     = (row_w == rows_eff - CW'(1)) ? '0 : row_w + CW'(1);
        cp_w     = (col_w == '0) ? cols_eff - CW'(1) : col_w - CW'(1);
        cn_w     = (col_w == cols_eff - CW'(1)) ? '0 : col_w + CW'(1);
        site_err = (row_w >= rows_eff) || (col_w >= cols_eff);

        o_ready     = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        o_valid     = r_out_valid;
        in_acc      = i_valid && o_ready;
        done        = (r_state == S_EV) && (!r_out_valid || i_ready);

        n_up = r_up;
        if (!r_err) begin
            n_up = r_up + CNT_W'(ev_res.up_inc) - CNT_W'(ev_res.up_dec);
        end
        area     = rows_eff * cols_eff;
        mag_full = (MW'(n_up) << 1) - MW'(area);

        mem_we    = (r_state == S_CLR) || (done && !r_err);
        mem_waddr = (r_state == S_CLR) ? r_clr : r_r;
        mem_wdata = (r_state == S_CLR) ? '0 : ev_row_new;
        mem_re0   = in_acc || (r_state == S_RD);
        mem_re1   = in_acc;
        mem_raddr0 = (r_state == S_RD) ? r_rn : row_w[IDX_W-1:0];
    end

    ims_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_re0    (mem_re0),
        .i_raddr0 (mem_raddr0),
        .o_rdata0 (mem_rdata0),
        .i_re1    (mem_re1),
        .i_raddr1 (rp_w[IDX_W-1:0]),
        .o_rdata1 (mem_rdata1)
    );

    ims_site_eval #(
        .MAX_SIDE  (MAX_SIDE),
        .PROB_BITS (PROB_BITS)
    ) u_eval (
        .i_row_c   (r_row_c),
        .i_row_p   (r_row_p),
        .i_row_n   (mem_rdata0),
        .i_col     (r_c),
        .i_col_p   (r_cp),
        .i_col_n   (r_cn),
        .i_op      (r_op),
        .i_spin_in (r_spin),
        .i_rand_u  (r_rand),
        .i_tab_dn  (r_tab_dn),
        .i_tab_up  (r_tab_up),
        .o_res     (ev_res),
        .o_row_new (ev_row_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_rows      <= ims_pkg::SIDE_RST;
            r_cols      <= ims_pkg::SIDE_RST;
            r_tab_dn    <= ims_pkg::TAB_RST;
            r_tab_up    <= ims_pkg::TAB_RST;
            r_up        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (ims_pkg::t_cfg_idx'(i_cfg_index))
                    ims_pkg::CFG_ROWS:   r_rows   <= i_cfg_data[ims_pkg::SIDE_REG_W-1:0];
                    ims_pkg::CFG_COLS:   r_cols   <= i_cfg_data[ims_pkg::SIDE_REG_W-1:0];
                    ims_pkg::CFG_TAB_DN: r_tab_dn <= i_cfg_data[ims_pkg::TAB_W-1:0];
                    ims_pkg::CFG_TAB_UP: r_tab_up <= i_cfg_data[ims_pkg::TAB_W-1:0];
                endcase
            end
            if (o_valid && i_ready && !done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(MAX_SIDE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_RD;
                        r_r     <= row_w[IDX_W-1:0];
                        r_rn    <= rn_w[IDX_W-1:0];
                        r_c     <= col_w[IDX_W-1:0];
                        r_cp    <= cp_w[IDX_W-1:0];
                        r_cn    <= cn_w[IDX_W-1:0];
                        r_op    <= i_op;
                        r_spin  <= i_spin_in;
                        r_rand  <= i_rand_u;
                        r_err   <= site_err;
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                    r_row_c <= mem_rdata0;
                    r_row_p <= mem_rdata1;
                end
                S_EV: begin
                    if (done) begin
                        r_state         <= S_IDLE;
                        r_up            <= n_up;
                        r_out_valid     <= 1'b1;
                        o_accepted      <= !r_err && ev_res.accepted;
                        o_spin_out      <= !r_err && ev_res.spin_out;
                        o_delta_index   <= r_err ? '0 : ev_res.delta_index;
                        o_site_error    <= r_err;
                        o_magnetization <= mag_full[ims_pkg::MAG_W-1:0];
                    end
                end
            endcase
        end
    end

`ifndef SYNTH
    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_RD))
        else $error("accepted transaction did not start the row reads");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_EV))
        else $error("result appeared outside evaluation");

    a_up_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_up <= CNT_W'(MAX_SIDE * MAX_SIDE))
        else $error("up-spin count beyond lattice size");

    a_no_write_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV && r_err) |-> !mem_we)
        else $error("out-of-range site written");
`endif

endmodule
